[sv/bsed_pkg.sv]
`timescale 1ns / 1ps

package bsed_pkg;

	// Hold buffer: up to four held bytes plus the incoming one
	localparam int BUF_BYTES = 5;
	localparam int BUF_W     = BUF_BYTES * 8;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_INTERPRET = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_NEWLINE   = 1'b1;

	// Character codes
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LOW_C  = 8'h63;
	localparam logic [7:0] CH_LOW_X  = 8'h78;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_ESC    = 8'h1B;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       byte_valid;
		logic       arg_end;
		logic       command_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
	} out_item_t;

	// One decode step at the head of the hold buffer
	typedef struct packed {
		logic       hold;    // wait for more bytes
		logic       cut;     // \c seen: drop the rest of the argument
		logic [1:0] n_emit;  // bytes produced by this step
		logic [7:0] b0;
		logic [7:0] b1;
		logic [2:0] adv;     // bytes consumed
	} step_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT2,
		ST_FINISH,
		ST_FLUSH
	} state_t;

	// {ok, value}
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [7:0] d;
		d = 8'h00;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = c - 8'h30;
			return {1'b1, d[3:0]};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			d = c - 8'h57;
			return {1'b1, d[3:0]};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			d = c - 8'h37;
			return {1'b1, d[3:0]};
		end
		return 5'b0_0000;
	endfunction

	// {ok, value}
	function automatic logic [3:0] oct_val(input logic [7:0] c);
		return {(c >= 8'h30 && c <= 8'h37), c[2:0]};
	endfunction

	// {ok, code} for the single-letter escapes
	function automatic logic [8:0] simple_code(input logic [7:0] c);
		logic [8:0] r;
		unique case (c)
			8'h61:   r = {1'b1, 8'h07};
			8'h62:   r = {1'b1, 8'h08};
			8'h65:   r = {1'b1, CH_ESC};
			8'h45:   r = {1'b1, CH_ESC};
			8'h66:   r = {1'b1, 8'h0C};
			8'h6E:   r = {1'b1, CH_NL};
			8'h72:   r = {1'b1, 8'h0D};
			8'h74:   r = {1'b1, 8'h09};
			8'h76:   r = {1'b1, 8'h0B};
			8'h5C:   r = {1'b1, CH_BSLASH};
			default: r = 9'h000;
		endcase
		return r;
	endfunction

endpackage

[sv/bsed_chan_if.sv]
`timescale 1ns / 1ps

interface bsed_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[sv/backslash_escape_decoder.sv]
// Sequencing: an item is taken in ST_IDLE; the sequencer then runs ST_SCAN for each decode
//   step, ST_EMIT2 for the second byte of a two-byte step, ST_SCAN again to find the buffer
//   empty or held, ST_FINISH to close the item and ST_FLUSH to release the final beat.
// Throughput: one item at a time; output stalls hold the sequencer. The final beat waits
//   in the output register while the next item is taken.
// Reset (arst_n low, asynchronous): nothing held, no cut pending, no space owed,
//   escapes off, newline on; there is no clearing pass.
`timescale 1ns / 1ps

module backslash_escape_decoder (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bsed_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic                             cfg_wdata,
	bsed_chan_if.sink                        in_chan,
	bsed_chan_if.source                      out_chan
);
	import bsed_pkg::*;

	// Configuration
	logic interpret_q;
	logic newline_q;

	// Sequencer and item state
	state_t     state_q, state_d;
	logic [2:0] n_q;         // bytes in the hold buffer
	logic [BUF_W-1:0] buf_q; // byte 0 at the top
	logic       discard_q;   // \c seen in this argument
	logic       seen_q;      // a space is owed before the next argument
	logic       end_q;
	logic       cmd_q;
	logic [7:0] b1_q;        // second byte of a two-byte step

	// One-beat staging: a beat waits here until we know whether it is the last
	logic [7:0] stg_q;
	logic       stg_v_q;

	// Output register
	logic [7:0] out_byte_q;
	logic       run_last_q;
	logic       out_valid_q;

	step_t step;
	logic  accept;
	logic  take;
	logic  go;

	// Control from the output decode
	logic       emit_en;
	logic [7:0] emit_b;
	logic       push_en;
	logic       push_last;
	logic       adv_en;
	logic       load_b1;
	logic       cut_en;
	logic       close_en;

	bsed_step u_step (
		.win    (buf_q),
		.n      (n_q),
		.at_end (end_q),
		.interp (interpret_q),
		.step   (step)
	);

	assign in_chan.ready = (state_q == ST_IDLE);
	assign accept        = in_chan.valid && in_chan.ready;
	assign take          = in_chan.data.byte_valid && !discard_q;

	// Advance only when a staged beat has somewhere to go
	assign go = !stg_v_q || !out_valid_q || out_chan.ready;

	assign out_chan.valid         = out_valid_q;
	assign out_chan.data.out_byte = out_byte_q;
	assign out_chan.data.run_last = run_last_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (n_q == 3'd0 || step.hold || step.cut) begin
					state_d = ST_FINISH;
				end else if (go && step.n_emit == 2'd2) begin
					state_d = ST_EMIT2;
				end
			end
			ST_EMIT2: begin
				if (go) state_d = ST_SCAN;
			end
			ST_FINISH: begin
				if (go) state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (go) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		emit_en   = 1'b0;
		emit_b    = step.b0;
		push_last = 1'b0;
		adv_en    = 1'b0;
		load_b1   = 1'b0;
		cut_en    = 1'b0;
		close_en  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
			end
			ST_SCAN: begin
				if (n_q == 3'd0 || step.hold) begin
					// leave the held bytes where they are
				end else if (step.cut) begin
					cut_en = 1'b1;
				end else if (go) begin
					emit_en = (step.n_emit != 2'd0);
					adv_en  = 1'b1;
					load_b1 = (step.n_emit == 2'd2);
				end
			end
			ST_EMIT2: begin
				emit_en = go;
				emit_b  = b1_q;
			end
			ST_FINISH: begin
				close_en = go && end_q;
				emit_en  = go && end_q && cmd_q && newline_q;
				emit_b   = CH_NL;
			end
			ST_FLUSH: begin
				push_last = go && stg_v_q;
			end
			default: begin
			end
		endcase
	end

	// A new beat pushes the staged one out; the flush pushes it as last
	assign push_en = (emit_en && stg_v_q) || push_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interpret_q <= 1'b0;
			newline_q   <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_INTERPRET: interpret_q <= cfg_wdata;
				CFG_NEWLINE:   newline_q   <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			n_q       <= 3'd0;
			discard_q <= 1'b0;
			seen_q    <= 1'b0;
			stg_v_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				n_q <= n_q + {2'b00, take};
				if (seen_q) begin
					seen_q  <= 1'b0;
					stg_v_q <= 1'b1;
				end
			end
			if (adv_en) n_q <= n_q - step.adv;
			if (cut_en) begin
				n_q       <= 3'd0;
				discard_q <= 1'b1;
			end
			if (close_en) begin
				n_q       <= 3'd0;
				discard_q <= 1'b0;
				seen_q    <= !cmd_q;
			end
			if (emit_en) stg_v_q <= 1'b1;
			if (push_last) stg_v_q <= 1'b0;
		end
	end

	// Payload: hold buffer, flags of the current item, staged beat
	always_ff @(posedge clk) begin
		if (accept) begin
			end_q <= in_chan.data.arg_end || in_chan.data.command_end;
			cmd_q <= in_chan.data.command_end;
			for (int i = 0; i < BUF_BYTES; i++) begin
				if (take && n_q == 3'(i)) buf_q[BUF_W-1-8*i -: 8] <= in_chan.data.in_byte;
			end
			if (seen_q) stg_q <= CH_SPACE;
		end
		if (adv_en) buf_q <= buf_q << {step.adv, 3'b000};
		if (load_b1) b1_q <= step.b1;
		if (emit_en) stg_q <= emit_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push_en) begin
			out_valid_q <= 1'b1;
		end else if (out_chan.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_en) begin
			out_byte_q <= stg_q;
			run_last_q <= push_last;
		end
	end

`ifndef SYNTHESIS
	a_idle_stage_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !stg_v_q)
		else $error("staged beat left over at idle");

	a_held_fits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> n_q <= 3'd4)
		else $error("more than four bytes held");

	a_held_starts_escape: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && n_q != 3'd0) |-> buf_q[BUF_W-1 -: 8] == CH_BSLASH)
		else $error("held bytes do not start with a backslash");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(push_en && out_valid_q) |-> out_chan.ready)
		else $error("output beat overwritten while stalled");

	a_cut_clears_buffer: assert property (@(posedge clk) disable iff (!arst_n)
		cut_en |=> (n_q == 3'd0 && discard_q))
		else $error("cut did not drop the buffer");
`endif

endmodule

[sv/bsed_step.sv]
`timescale 1ns / 1ps

module bsed_step (
	input  logic [bsed_pkg::BUF_W-1:0] win,
	input  logic [2:0]                 n,
	input  logic                       at_end,
	input  logic                       interp,
	output bsed_pkg::step_t            step
);
	import bsed_pkg::*;

	logic [7:0] c, k, e2, e3, e4;
	logic [8:0] sc;
	logic [4:0] h1, h2;
	logic [3:0] d1, d2, d3;

	assign c  = win[BUF_W-1 -: 8];
	assign k  = win[BUF_W-9 -: 8];
	assign e2 = win[BUF_W-17 -: 8];
	assign e3 = win[BUF_W-25 -: 8];
	assign e4 = win[BUF_W-33 -: 8];
	assign sc = simple_code(k);
	assign h1 = hex_val(e2);
	assign h2 = hex_val(e3);
	assign d1 = oct_val(e2);
	assign d2 = oct_val(e3);
	assign d3 = oct_val(e4);

	always_comb begin
		step = '0;
		priority if (!interp || c != CH_BSLASH) begin
			step.n_emit = 2'd1;
			step.b0     = c;
			step.adv    = 3'd1;
		end else if (n < 3'd2) begin
			if (!at_end) begin
				step.hold = 1'b1;
			end else begin
				step.n_emit = 2'd1;
				step.b0     = CH_BSLASH;
				step.adv    = 3'd1;
			end
		end else if (sc[8]) begin
			step.n_emit = 2'd1;
			step.b0     = sc[7:0];
			step.adv    = 3'd2;
		end else if (k == CH_LOW_C) begin
			step.cut = 1'b1;
		end else if (k == CH_LOW_X) begin
			if (n < 3'd4 && !at_end) begin
				step.hold = 1'b1;
			end else if (n < 3'd4 || !h1[4]) begin
				step.n_emit = 2'd2;
				step.b0     = CH_BSLASH;
				step.b1     = k;
				step.adv    = 3'd2;
			end else if (!h2[4]) begin
				step.n_emit = 2'd1;
				step.b0     = {4'h0, h1[3:0]};
				step.adv    = 3'd3;
			end else begin
				// drop values of 128 and up
				step.n_emit = h1[3] ? 2'd0 : 2'd1;
				step.b0     = {h1[3:0], h2[3:0]};
				step.adv    = 3'd4;
			end
		end else if (k == CH_ZERO) begin
			if (n < 3'd5 && !at_end) begin
				step.hold = 1'b1;
			end else if (n < 3'd5 || !d1[3]) begin
				step.n_emit = 2'd2;
				step.b0     = CH_BSLASH;
				step.b1     = k;
				step.adv    = 3'd2;
			end else if (!d2[3]) begin
				step.n_emit = 2'd1;
				step.b0     = {5'h00, d1[2:0]};
				step.adv    = 3'd3;
			end else if (!d3[3]) begin
				step.n_emit = 2'd1;
				step.b0     = {2'b00, d1[2:0], d2[2:0]};
				step.adv    = 3'd4;
			end else begin
				step.n_emit = (d1[2:1] != 2'b00) ? 2'd0 : 2'd1;
				step.b0     = {1'b0, d1[0], d2[2:0], d3[2:0]};
				step.adv    = 3'd5;
			end
		end else begin
			step.n_emit = 2'd2;
			step.b0     = CH_BSLASH;
			step.b1     = k;
			step.adv    = 3'd2;
		end
	end

endmodule

[test/backslash_escape_decoder_tb.sv]
`timescale 1ns / 1ps

module backslash_escape_decoder_tb;
	import bsed_pkg::*;

	localparam int DRAIN_CYCLES = 20;   // settling time after the queues empty, with margin
	localparam int IDLE_LIMIT   = 2000; // cycles without any beat before giving up
	localparam int LONG_HOLD    = 300;  // receiver hold-off that backs up the input
	localparam int PHASE_ITEMS  = 70;   // random items per configuration phase

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic cfg_wdata;

	bsed_chan_if #(.payload_t(in_item_t))  in_chan ();
	bsed_chan_if #(.payload_t(out_item_t)) out_chan ();

	backslash_escape_decoder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_chan   (in_chan),
		.out_chan  (out_chan)
	);

	always #5 clk = ~clk;

	// Items waiting for the driver and decoded bytes waiting for the output
	in_item_t  arg_items [$];
	out_item_t decoded_q [$];
	int items_queued = 0;
	int items_taken  = 0;
	bit failed = 1'b0;

	// Shadow of the block: configuration and decoder state
	bit         esc_on = 1'b0;
	bit         nl_on = 1'b1;
	logic [7:0] held [4];
	int         held_n = 0;
	bit         cut_on = 1'b0;
	bit         space_owed = 1'b0;

	// Handshake flags sampled at the rising edge, consumed at the falling edge
	bit in_took = 1'b0;
	bit out_took = 1'b0;
	bit long_hold_req = 1'b0;

	function automatic int hex_digit(input logic [7:0] c);
		if (c >= "0" && c <= "9") return c - "0";
		if (c >= "a" && c <= "f") return c - "a" + 10;
		if (c >= "A" && c <= "F") return c - "A" + 10;
		return -1;
	endfunction

	function automatic int oct_digit(input logic [7:0] c);
		if (c >= "0" && c <= "7") return c - "0";
		return -1;
	endfunction

	function automatic bit escape_code(input logic [7:0] c, output logic [7:0] code);
		escape_code = 1'b1;
		case (c)
			"a":       code = 8'h07;
			"b":       code = 8'h08;
			"e", "E":  code = CH_ESC;
			"f":       code = 8'h0C;
			"n":       code = CH_NL;
			"r":       code = 8'h0D;
			"t":       code = 8'h09;
			"v":       code = 8'h0B;
			CH_BSLASH: code = CH_BSLASH;
			default: begin
				code = 8'h00;
				escape_code = 1'b0;
			end
		endcase
	endfunction

	// Decode one accepted item against the shadow state and queue the bytes it yields
	task automatic decode_item(input in_item_t it);
		logic [7:0] scan [5];
		logic [7:0] res [$];
		logic [7:0] k, code;
		int n, p, h1, h2, d1, d2, d3, n_out;
		bit fin, stop;
		out_item_t beat;
		fin = it.arg_end || it.command_end;
		n = 0;
		p = 0;
		stop = 1'b0;
		if (space_owed) begin
			res.push_back(CH_SPACE);
			space_owed = 1'b0;
		end
		for (int i = 0; i < held_n; i++) begin
			scan[n] = held[i];
			n++;
		end
		if (it.byte_valid && !cut_on) begin
			scan[n] = it.in_byte;
			n++;
		end
		if (!esc_on) begin
			for (int i = 0; i < n; i++) res.push_back(scan[i]);
			p = n;
		end
		while (esc_on && !stop && p < n) begin
			if (scan[p] != CH_BSLASH) begin
				res.push_back(scan[p]);
				p++;
			end else if (p + 1 >= n) begin
				// lone backslash: wait for more unless the argument closes here
				if (fin) begin
					res.push_back(CH_BSLASH);
					p++;
				end else stop = 1'b1;
			end else begin
				k = scan[p + 1];
				if (escape_code(k, code)) begin
					res.push_back(code);
					p += 2;
				end else if (k == CH_LOW_C) begin
					// cut: drop whatever is left of the argument
					cut_on = 1'b1;
					p = n;
				end else if (k == CH_LOW_X) begin
					if (n - p - 2 < 2) begin
						if (fin) begin
							res.push_back(CH_BSLASH);
							res.push_back(k);
							p += 2;
						end else stop = 1'b1;
					end else begin
						h1 = hex_digit(scan[p + 2]);
						h2 = hex_digit(scan[p + 3]);
						if (h1 < 0) begin
							res.push_back(CH_BSLASH);
							res.push_back(k);
							p += 2;
						end else if (h2 < 0) begin
							res.push_back(8'(h1));
							p += 3;
						end else begin
							if (h1 * 16 + h2 < 128) res.push_back(8'(h1 * 16 + h2));
							p += 4;
						end
					end
				end else if (k == CH_ZERO) begin
					if (n - p - 2 < 3) begin
						if (fin) begin
							res.push_back(CH_BSLASH);
							res.push_back(k);
							p += 2;
						end else stop = 1'b1;
					end else begin
						d1 = oct_digit(scan[p + 2]);
						d2 = oct_digit(scan[p + 3]);
						d3 = oct_digit(scan[p + 4]);
						if (d1 < 0) begin
							res.push_back(CH_BSLASH);
							res.push_back(k);
							p += 2;
						end else if (d2 < 0) begin
							res.push_back(8'(d1));
							p += 3;
						end else if (d3 < 0) begin
							res.push_back(8'(d1 * 8 + d2));
							p += 4;
						end else begin
							if ((d1 * 8 + d2) * 8 + d3 < 128)
								res.push_back(8'((d1 * 8 + d2) * 8 + d3));
							p += 5;
						end
					end
				end else begin
					// unknown escape passes through as written
					res.push_back(CH_BSLASH);
					res.push_back(k);
					p += 2;
				end
			end
		end
		// hold the undecided tail for the next item
		held_n = (n - p > 4) ? 4 : n - p;
		for (int i = 0; i < held_n; i++) held[i] = scan[p + i];
		if (fin) begin
			held_n = 0;
			cut_on = 1'b0;
			if (it.command_end) begin
				if (nl_on) res.push_back(CH_NL);
				space_owed = 1'b0;
			end else space_owed = 1'b1;
		end
		n_out = (res.size() > 8) ? 8 : res.size();
		for (int i = 0; i < n_out; i++) begin
			beat.out_byte = res[i];
			beat.run_last = (i == n_out - 1);
			decoded_q.push_back(beat);
		end
	endtask

	// Sample both channels at the rising edge: predict on input beats, check output beats
	always @(posedge clk) begin
		out_item_t want;
		in_took = arst_n && in_chan.valid && in_chan.ready;
		out_took = arst_n && out_chan.valid && out_chan.ready;
		if (in_took) begin
			decode_item(in_chan.data);
			items_taken++;
		end
		if (out_took) begin
			if (decoded_q.size() == 0) begin
				$error("unexpected beat: out_byte=%h run_last=%b",
					out_chan.data.out_byte, out_chan.data.run_last);
				failed = 1'b1;
			end else begin
				want = decoded_q.pop_front();
				if (want.out_byte !== out_chan.data.out_byte) begin
					$error("out_byte: expected %h, got %h", want.out_byte,
						out_chan.data.out_byte);
					failed = 1'b1;
				end
				if (want.run_last !== out_chan.data.run_last) begin
					$error("run_last: expected %b, got %b", want.run_last,
						out_chan.data.run_last);
					failed = 1'b1;
				end
			end
		end
	end

	// Driver: offer items in bursts, hold a beat until it is taken
	int burst_left = 0;
	int gap_left = 0;

	always @(negedge clk) begin
		if (!in_chan.valid || in_took) begin
			if (gap_left > 0 || arg_items.size() == 0) begin
				if (gap_left > 0) gap_left--;
				in_chan.valid <= 1'b0;
			end else begin
				in_chan.data <= arg_items.pop_front();
				in_chan.valid <= 1'b1;
				if (burst_left > 0) burst_left--;
				else begin
					burst_left = $urandom_range(0, 20);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
	end

	// Receiver: stall on a changing pattern, plus one long hold-off on request
	int stall_mode = 0;
	int mode_left = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	always @(negedge clk) begin
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			mode_left = 64;
		end
		mode_left--;
		if (long_hold_req && !hold_done) begin
			hold_left = LONG_HOLD;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_chan.ready <= 1'b0;
		end else begin
			case (stall_mode)
				0: out_chan.ready <= 1'b1;
				1: out_chan.ready <= ($urandom_range(0, 2) != 0);
				2: out_chan.ready <= (mode_left % 3 != 0);
				default: out_chan.ready <= ($urandom_range(0, 2) == 0);
			endcase
		end
	end

	// Watchdog: count cycles with no beat on either side
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (in_took || out_took) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("backslash_escape_decoder_tb NOT OK");
			$finish;
		end
	end

	task automatic add_item(input logic [7:0] b, input bit v, input bit ae, input bit ce);
		in_item_t it;
		it.in_byte = b;
		it.byte_valid = v;
		it.arg_end = ae;
		it.command_end = ce;
		arg_items.push_back(it);
		items_queued++;
	endtask

	// Queue a string as one byte per item, end flags on its last byte
	task automatic add_text(input string s, input bit ae, input bit ce);
		for (int i = 0; i < s.len(); i++)
			add_item(s[i], 1'b1, ae && i == s.len() - 1, ce && i == s.len() - 1);
	endtask

	function automatic logic [7:0] pick_hex();
		string digits;
		digits = "0123456789abcdefABCDEF";
		if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
		return digits[$urandom_range(0, 21)];
	endfunction

	function automatic logic [7:0] pick_oct();
		if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
		if ($urandom_range(0, 9) == 0) return "8";
		return 8'("0" + $urandom_range(0, 7));
	endfunction

	// One command of 1..4 arguments built from escape-heavy tokens
	task automatic add_random_command();
		logic [7:0] text [$];
		string letters;
		int n_args, n_tok, cut_len;
		bit last_arg, use_marker, end_here;
		letters = "abeEfnrtv\\";
		n_args = $urandom_range(1, 4);
		for (int a = 0; a < n_args; a++) begin
			text.delete();
			n_tok = $urandom_range(0, 5);
			for (int t = 0; t < n_tok; t++) begin
				case ($urandom_range(0, 15))
					0, 1, 2: text.push_back(8'($urandom_range(32, 126)));
					3: text.push_back(8'($urandom_range(0, 255)));
					4, 5: begin
						text.push_back(CH_BSLASH);
						text.push_back(letters[$urandom_range(0, 9)]);
					end
					6, 7, 8: begin
						text.push_back(CH_BSLASH);
						text.push_back(CH_LOW_X);
						repeat (2) text.push_back(pick_hex());
					end
					9, 10, 11: begin
						text.push_back(CH_BSLASH);
						text.push_back(CH_ZERO);
						repeat (3) text.push_back(pick_oct());
					end
					12: begin
						text.push_back(CH_BSLASH);
						text.push_back(CH_LOW_C);
					end
					13: begin
						text.push_back(CH_BSLASH);
						text.push_back(8'($urandom_range(0, 255)));
					end
					default: text.push_back(CH_BSLASH);
				endcase
			end
			// sometimes chop the tail so escapes run into the argument's end
			if (text.size() > 0 && $urandom_range(0, 3) == 0) begin
				cut_len = $urandom_range(1, 2);
				while (cut_len > 0 && text.size() > 0) begin
					void'(text.pop_back());
					cut_len--;
				end
			end
			last_arg = (a == n_args - 1);
			use_marker = (text.size() == 0) || ($urandom_range(0, 5) == 0);
			for (int i = 0; i < text.size(); i++) begin
				if ($urandom_range(0, 19) == 0)
					add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
				end_here = (i == text.size() - 1) && !use_marker;
				add_item(text[i], 1'b1, end_here && (!last_arg || $urandom_range(0, 1)),
					end_here && last_arg);
			end
			if (use_marker)
				add_item(8'($urandom_range(0, 255)), 1'b0,
					!last_arg || $urandom_range(0, 1), last_arg);
		end
	endtask

	// Wait until every queued item is in and every decoded byte is out, then let it drain
	task automatic settle();
		while (items_taken != items_queued || decoded_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input bit val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		if (idx == CFG_INTERPRET) esc_on = val;
		else nl_on = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(input bit esc, input bit nl);
		int start;
		settle();
		write_reg(CFG_INTERPRET, esc);
		write_reg(CFG_NEWLINE, nl);
		start = items_queued;
		while (items_queued - start < PHASE_ITEMS) add_random_command();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = CFG_INTERPRET;
		cfg_wdata = 1'b0;
		in_chan.valid = 1'b0;
		in_chan.data = '0;
		out_chan.ready = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Directed: escapes on, no trailing newline
		write_reg(CFG_INTERPRET, 1'b1);
		write_reg(CFG_NEWLINE, 1'b0);
		add_text("\\x7F", 1'b1, 1'b0);      // largest hex value that survives
		add_text("\\xFg", 1'b1, 1'b0);      // good first digit, bad second
		add_text("\\0377\\0", 1'b1, 1'b0);  // octal over 127 dropped, then short \0
		add_text("x\\cab", 1'b1, 1'b0);     // cut drops the rest
		add_text("\\E\\q\\", 1'b1, 1'b0);   // escape letter, unknown, backslash at end
		add_item(8'h00, 1'b1, 1'b0, 1'b0);
		add_item(8'hA5, 1'b0, 1'b0, 1'b0);  // empty item adds no byte
		add_item(8'hFF, 1'b1, 1'b0, 1'b0);
		add_item(8'h5A, 1'b0, 1'b1, 1'b1);  // end marker closes the command
		add_item(8'h00, 1'b0, 1'b0, 1'b1);  // empty command
		settle();
		write_reg(CFG_NEWLINE, 1'b1);

		// Bytes held when escapes go off come out raw with the next item
		add_text("\\x4", 1'b0, 1'b0);
		settle();
		write_reg(CFG_INTERPRET, 1'b0);
		add_text("Z", 1'b0, 1'b1);

		// A cut stays in force with escapes off until the argument ends
		settle();
		write_reg(CFG_INTERPRET, 1'b1);
		add_text("\\c", 1'b0, 1'b0);
		settle();
		write_reg(CFG_INTERPRET, 1'b0);
		add_text("yy", 1'b1, 1'b1);

		// Random phases; the first one runs under the long receiver hold-off
		random_phase(1'b1, 1'b1);
		long_hold_req = 1'b1;
		random_phase(1'b1, 1'b0);
		random_phase(1'b0, 1'b1);
		random_phase(1'b1, 1'b1);

		settle();
		if (!failed && decoded_q.size() == 0) begin
			$display("backslash_escape_decoder_tb OK");
		end else begin
			$display("backslash_escape_decoder_tb NOT OK");
		end
		$finish;
	end

endmodule
